FILE: rtl/mlfc_pkg.sv
// ----------------------------------------------------------------------------
// mlfc_pkg
// shared types, widths and constants of the motion light fade controller
// ----------------------------------------------------------------------------
package mlfc_pkg;

    localparam int unsigned AMBIENT_W   = 10;
    localparam int unsigned LEVEL_W     = 8;
    localparam int unsigned MODE_W      = 2;
    localparam int unsigned THRESH_W    = 10;
    localparam int unsigned HOLD_W      = 16;
    localparam int unsigned ELAPSED_W   = 17;
    localparam int unsigned STEP_W      = 8;
    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 16;

    localparam logic [LEVEL_W-1:0]   LEVEL_MAX = 8'd255;
    localparam logic [ELAPSED_W-1:0] HOLD_SAT  = 17'h1FFFF;

    // register reset values
    localparam logic [THRESH_W-1:0] DARK_THRESHOLD_RST  = 10'd500;
    localparam logic [HOLD_W-1:0]   HOLD_TICKS_RST      = 16'd10000;
    localparam logic [STEP_W-1:0]   FADE_STEP_TICKS_RST = 8'd10;

    // register indexes on the configuration port
    localparam logic [CFG_INDEX_W-1:0] CFG_DARK_THRESHOLD  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_HOLD_TICKS      = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_FADE_STEP_TICKS = 2'd2;

    typedef enum logic [MODE_W-1:0] {
        MODE_IDLE = 2'd0,
        MODE_UP   = 2'd1,
        MODE_HOLD = 2'd2,
        MODE_DOWN = 2'd3
    } t_mode;

    typedef struct packed {
        logic [THRESH_W-1:0] dark_threshold;
        logic [HOLD_W-1:0]   hold_ticks;
        logic [STEP_W-1:0]   fade_step_ticks;
    } t_cfg;

endpackage

FILE: rtl/mlfc_tick_if.sv
// ----------------------------------------------------------------------------
// mlfc_tick_if
// request channel carrying one millisecond tick: motion bit and light sample
// ----------------------------------------------------------------------------
interface mlfc_tick_if;
    logic                             valid;
    logic                             ready;
    logic                             motion;
    logic [mlfc_pkg::AMBIENT_W-1:0]   ambient_level;

    modport source (output valid, output motion, output ambient_level, input ready);
    modport sink   (input valid, input motion, input ambient_level, output ready);
endinterface

FILE: rtl/mlfc_result_if.sv
// ----------------------------------------------------------------------------
// mlfc_result_if
// result channel: brightness level and mode after each tick
// ----------------------------------------------------------------------------
interface mlfc_result_if;
    logic                           valid;
    logic                           ready;
    logic [mlfc_pkg::LEVEL_W-1:0]   brightness;
    logic [mlfc_pkg::MODE_W-1:0]    light_mode;

    modport source (output valid, output brightness, output light_mode, input ready);
    modport sink   (input valid, input brightness, input light_mode, output ready);
endinterface

FILE: rtl/mlfc_cfg_regs.sv
// ----------------------------------------------------------------------------
// mlfc_cfg_regs
// configuration register file, write only
// ----------------------------------------------------------------------------
module mlfc_cfg_regs (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [mlfc_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [mlfc_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output mlfc_pkg::t_cfg                      o_cfg
);

    mlfc_pkg::t_cfg r_cfg;
    mlfc_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_index)
                mlfc_pkg::CFG_DARK_THRESHOLD: begin
                    n_cfg.dark_threshold = i_cfg_data[mlfc_pkg::THRESH_W-1:0];
                end
                mlfc_pkg::CFG_HOLD_TICKS: begin
                    n_cfg.hold_ticks = i_cfg_data[mlfc_pkg::HOLD_W-1:0];
                end
                mlfc_pkg::CFG_FADE_STEP_TICKS: begin
                    n_cfg.fade_step_ticks = i_cfg_data[mlfc_pkg::STEP_W-1:0];
                end
                default: begin
                    // unknown index, write dropped
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dark_threshold  <= mlfc_pkg::DARK_THRESHOLD_RST;
            r_cfg.hold_ticks      <= mlfc_pkg::HOLD_TICKS_RST;
            r_cfg.fade_step_ticks <= mlfc_pkg::FADE_STEP_TICKS_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: rtl/mlfc_fade_core.sv
// ----------------------------------------------------------------------------
// mlfc_fade_core
// mode state machine, brightness level, fade interval and hold timers
// ----------------------------------------------------------------------------
module mlfc_fade_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic                                i_motion,
    input  logic [mlfc_pkg::AMBIENT_W-1:0]      i_ambient_level,
    input  mlfc_pkg::t_cfg                      i_cfg,
    output logic [mlfc_pkg::LEVEL_W-1:0]        o_brightness,
    output logic [mlfc_pkg::MODE_W-1:0]         o_light_mode
);

    mlfc_pkg::t_mode                    r_mode;
    mlfc_pkg::t_mode                    n_mode;
    logic [mlfc_pkg::LEVEL_W-1:0]       r_level;
    logic [mlfc_pkg::LEVEL_W-1:0]       n_level;
    logic [mlfc_pkg::STEP_W-1:0]        r_step_count;
    logic [mlfc_pkg::STEP_W-1:0]        n_step_count;
    logic [mlfc_pkg::ELAPSED_W-1:0]     r_hold_elapsed;
    logic [mlfc_pkg::ELAPSED_W-1:0]     n_hold_elapsed;

    logic [mlfc_pkg::STEP_W-1:0]        interval;
    logic [mlfc_pkg::STEP_W:0]          step_inc;
    logic                               step_due;
    logic [mlfc_pkg::ELAPSED_W-1:0]     hold_inc;
    logic [mlfc_pkg::LEVEL_W-1:0]       level_up;
    logic [mlfc_pkg::LEVEL_W-1:0]       level_down;

    // a zero interval behaves as one step per tick
    assign interval   = (i_cfg.fade_step_ticks == '0) ? mlfc_pkg::STEP_W'(1)
                                                      : i_cfg.fade_step_ticks;
    assign step_inc   = {1'b0, r_step_count} + (mlfc_pkg::STEP_W+1)'(1);
    assign step_due   = step_inc >= {1'b0, interval};
    assign hold_inc   = (r_hold_elapsed == mlfc_pkg::HOLD_SAT) ? r_hold_elapsed
                      : r_hold_elapsed + mlfc_pkg::ELAPSED_W'(1);
    assign level_up   = (r_level == mlfc_pkg::LEVEL_MAX) ? r_level
                      : r_level + mlfc_pkg::LEVEL_W'(1);
    assign level_down = r_level - mlfc_pkg::LEVEL_W'(1);

    always_comb begin
        n_mode         = r_mode;
        n_level        = r_level;
        n_step_count   = r_step_count;
        n_hold_elapsed = r_hold_elapsed;
        if (i_en) begin
            case (r_mode)
                mlfc_pkg::MODE_IDLE: begin
                    if (i_motion && (i_ambient_level < i_cfg.dark_threshold)) begin
                        n_step_count   = '0;
                        n_hold_elapsed = '0;
                        n_mode = (r_level == mlfc_pkg::LEVEL_MAX) ? mlfc_pkg::MODE_HOLD
                                                                   : mlfc_pkg::MODE_UP;
                    end
                end
                mlfc_pkg::MODE_UP: begin
                    if (step_due) begin
                        n_step_count = '0;
                        n_level      = level_up;
                        if (level_up == mlfc_pkg::LEVEL_MAX) begin
                            n_mode         = mlfc_pkg::MODE_HOLD;
                            n_hold_elapsed = '0;
                        end
                    end else begin
                        n_step_count = step_inc[mlfc_pkg::STEP_W-1:0];
                    end
                end
                mlfc_pkg::MODE_HOLD: begin
                    if (i_motion) begin
                        n_hold_elapsed = '0;
                    end else begin
                        n_hold_elapsed = hold_inc;
                        if (hold_inc > {1'b0, i_cfg.hold_ticks}) begin
                            n_mode       = mlfc_pkg::MODE_DOWN;
                            n_step_count = '0;
                        end
                    end
                end
                mlfc_pkg::MODE_DOWN: begin
                    if (r_level == '0) begin
                        n_mode       = mlfc_pkg::MODE_IDLE;
                        n_step_count = '0;
                    end else if (step_due) begin
                        n_step_count = '0;
                        n_level      = level_down;
                        // motion only aborts on a step tick
                        if (i_motion || (level_down == '0)) begin
                            n_mode = mlfc_pkg::MODE_IDLE;
                        end
                    end else begin
                        n_step_count = step_inc[mlfc_pkg::STEP_W-1:0];
                    end
                end
                default: begin
                    n_mode = mlfc_pkg::MODE_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode         <= mlfc_pkg::MODE_IDLE;
            r_level        <= '0;
            r_step_count   <= '0;
            r_hold_elapsed <= '0;
        end else begin
            r_mode         <= n_mode;
            r_level        <= n_level;
            r_step_count   <= n_step_count;
            r_hold_elapsed <= n_hold_elapsed;
        end
    end

    // result reflects the state after this tick
    assign o_brightness = n_level;
    assign o_light_mode = n_mode;

`ifndef SYNTHESIS
    a_hold_at_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode == mlfc_pkg::MODE_HOLD |-> r_level == mlfc_pkg::LEVEL_MAX)
        else $error("hold mode below full brightness");

    a_up_below_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode == mlfc_pkg::MODE_UP |-> r_level != mlfc_pkg::LEVEL_MAX)
        else $error("fade up at full brightness");

    a_idle_tick_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_en |=> $stable(r_mode) && $stable(r_level) && $stable(r_hold_elapsed))
        else $error("state moved without a tick");
`endif

endmodule

FILE: rtl/motion_light_fade_controller.sv
// ----------------------------------------------------------------------------
// motion_light_fade_controller
// presence triggered LED fader: idle, fade up, hold and fade down
// ----------------------------------------------------------------------------
// Every tick request (motion bit and ambient light sample) gives exactly one
// result request carrying the brightness and the mode after that tick. The
// block takes one tick per clock cycle while tick ready is high: a tick
// lands in an input register, then, once the result register is free or
// being emptied, the fade core updates its state and the result register
// captures the new brightness and mode. Ready on the tick channel only
// drops when both the input register and the result register hold data and
// the result side is stalled; the state update itself is combinational into
// the result register.
// Configuration writes (dark threshold, hold ticks, fade step ticks) take
// effect on the next tick and should only be made while no tick is in
// flight; writes to an unknown index are dropped.
// ----------------------------------------------------------------------------
module motion_light_fade_controller (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [mlfc_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [mlfc_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    mlfc_tick_if.sink                           s_tick,
    mlfc_result_if.source                       m_result
);

    mlfc_pkg::t_cfg                     cfg;

    // input register
    logic                               r_in_valid;
    logic                               r_in_motion;
    logic [mlfc_pkg::AMBIENT_W-1:0]     r_in_ambient_level;

    // result register
    logic                               r_out_valid;
    logic [mlfc_pkg::LEVEL_W-1:0]       r_out_brightness;
    logic [mlfc_pkg::MODE_W-1:0]        r_out_light_mode;

    logic                               advance;
    logic                               tick_take;
    logic [mlfc_pkg::LEVEL_W-1:0]       next_brightness;
    logic [mlfc_pkg::MODE_W-1:0]        next_light_mode;

    // the tick in the input register moves on when the result slot is free
    // or being emptied this cycle
    assign advance   = r_in_valid && (!r_out_valid || m_result.ready);
    assign tick_take = s_tick.valid && s_tick.ready;

    assign s_tick.ready = !r_in_valid || advance;

    mlfc_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // state advances exactly once per tick, as it leaves the input register
    mlfc_fade_core u_fade_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_en            (advance),
        .i_motion        (r_in_motion),
        .i_ambient_level (r_in_ambient_level),
        .i_cfg           (cfg),
        .o_brightness    (next_brightness),
        .o_light_mode    (next_light_mode)
    );

    // input stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_tick.ready) begin
            r_in_valid <= s_tick.valid;
        end
    end

    // input stage payload
    always_ff @(posedge i_clk) begin
        if (tick_take) begin
            r_in_motion        <= s_tick.motion;
            r_in_ambient_level <= s_tick.ambient_level;
        end
    end

    // result stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // result stage payload
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_brightness <= next_brightness;
            r_out_light_mode <= next_light_mode;
        end
    end

    assign m_result.valid      = r_out_valid;
    assign m_result.brightness = r_out_brightness;
    assign m_result.light_mode = r_out_light_mode;

`ifndef SYNTHESIS
    a_tick_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tick_take |=> r_in_valid)
        else $error("accepted tick lost before the input register");

    a_tick_reaches_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_out_valid)
        else $error("tick update produced no result");

    a_full_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out_light_mode == mlfc_pkg::MODE_HOLD)
            |-> r_out_brightness == mlfc_pkg::LEVEL_MAX)
        else $error("hold result below full brightness");
`endif

endmodule

FILE: verif/mlfc_tb_pkg.sv
// ----------------------------------------------------------------------------
// mlfc_tb_pkg
// scoreboard of the motion light fade controller: tracks the fader state and
// compares each result request against the level and mode it should carry
// ----------------------------------------------------------------------------
package mlfc_tb_pkg;

    import mlfc_pkg::*;

    // index with no register behind it, writes there must be dropped
    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = 2'd3;

    typedef struct packed {
        logic [LEVEL_W-1:0] brightness;
        t_mode              light_mode;
    } t_light_out;

    class fade_scoreboard;
        t_cfg                 cfg;
        t_mode                mode;
        logic [LEVEL_W-1:0]   level;
        logic [STEP_W-1:0]    step_count;
        logic [ELAPSED_W-1:0] hold_elapsed;
        t_light_out           expected_out[$];
        int unsigned          errors;
        int unsigned          checked;
        int unsigned          starts;
        int unsigned          expiries;
        int unsigned          aborts;
        int unsigned          fade_outs;
        int unsigned          mode_hits[4];

        function new();
            cfg.dark_threshold  = DARK_THRESHOLD_RST;
            cfg.hold_ticks      = HOLD_TICKS_RST;
            cfg.fade_step_ticks = FADE_STEP_TICKS_RST;
            mode         = MODE_IDLE;
            level        = '0;
            step_count   = '0;
            hold_elapsed = '0;
            errors       = 0;
            checked      = 0;
            starts       = 0;
            expiries     = 0;
            aborts       = 0;
            fade_outs    = 0;
            foreach (mode_hits[m]) mode_hits[m] = 0;
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_DARK_THRESHOLD:  cfg.dark_threshold  = data[THRESH_W-1:0];
                CFG_HOLD_TICKS:      cfg.hold_ticks      = data[HOLD_W-1:0];
                CFG_FADE_STEP_TICKS: cfg.fade_step_ticks = data[STEP_W-1:0];
                default: ;
            endcase
        endfunction

        // a zero interval behaves as one step per tick
        function bit fade_step_due();
            logic [STEP_W:0] interval;
            logic [STEP_W:0] next_count;
            interval   = (cfg.fade_step_ticks == '0) ? {{STEP_W{1'b0}}, 1'b1}
                                                     : {1'b0, cfg.fade_step_ticks};
            next_count = {1'b0, step_count} + 1'b1;
            if (next_count >= interval) begin
                step_count = '0;
                return 1'b1;
            end
            step_count = next_count[STEP_W-1:0];
            return 1'b0;
        endfunction

        function void tick_taken(logic motion, logic [AMBIENT_W-1:0] ambient);
            case (mode)
                MODE_IDLE: begin
                    if (motion && ambient < cfg.dark_threshold) begin
                        step_count   = '0;
                        hold_elapsed = '0;
                        mode         = (level == LEVEL_MAX) ? MODE_HOLD : MODE_UP;
                        starts++;
                    end
                end
                MODE_UP: begin
                    if (fade_step_due()) begin
                        if (level != LEVEL_MAX) level++;
                        if (level == LEVEL_MAX) begin
                            mode         = MODE_HOLD;
                            hold_elapsed = '0;
                        end
                    end
                end
                MODE_HOLD: begin
                    if (motion) begin
                        hold_elapsed = '0;
                    end else begin
                        if (hold_elapsed != HOLD_SAT) hold_elapsed++;
                        if (hold_elapsed > {1'b0, cfg.hold_ticks}) begin
                            mode       = MODE_DOWN;
                            step_count = '0;
                            expiries++;
                        end
                    end
                end
                default: begin
                    if (level == '0) begin
                        mode       = MODE_IDLE;
                        step_count = '0;
                    end else if (fade_step_due()) begin
                        level--;
                        // motion only counts on a tick that steps down
                        if (motion || level == '0) begin
                            if (level == '0) fade_outs++;
                            else aborts++;
                            mode       = MODE_IDLE;
                            step_count = '0;
                        end
                    end
                end
            endcase
            expected_out.push_back('{brightness: level, light_mode: mode});
        endfunction

        function void flag(realtime stamp, string what);
            errors++;
            $display("[%0.1f ns] %s", stamp, what);
        endfunction

        function void result_seen(logic [LEVEL_W-1:0] brightness, logic [MODE_W-1:0] light_mode,
                                  realtime stamp);
            t_light_out want;
            checked++;
            if (expected_out.size() == 0) begin
                flag(stamp, $sformatf("result with nothing expected: brightness %0d, mode %0d",
                                      brightness, light_mode));
                return;
            end
            want = expected_out.pop_front();
            mode_hits[want.light_mode]++;
            if (brightness !== want.brightness)
                flag(stamp, $sformatf("brightness mismatch: expected %0d, actual %0d",
                                      want.brightness, brightness));
            if (light_mode !== want.light_mode)
                flag(stamp, $sformatf("light_mode mismatch: expected %0d, actual %0d",
                                      want.light_mode, light_mode));
        endfunction

        function int unsigned pending();
            return expected_out.size();
        endfunction
    endclass

endpackage

FILE: verif/tb_motion_light_fade_controller.sv
// ----------------------------------------------------------------------------
// tb_motion_light_fade_controller
// drives tick requests through a run of register settings, from directed
// edge cases to long random stretches, and checks every brightness and mode
// result against a cycle-free model of the fader held in a scoreboard
// ----------------------------------------------------------------------------
module tb_motion_light_fade_controller;

    timeunit 1ns;
    timeprecision 1ps;

    import mlfc_pkg::*;
    import mlfc_tb_pkg::*;

    localparam int unsigned CLK_HALF_NS       = 6;
    localparam int unsigned RESET_CYCLES      = 11;
    // result passes the input and result registers after its tick, keep a little margin
    localparam int unsigned SETTLE_CYCLES     = 4;
    localparam int unsigned LONG_STALL_CYCLES = 90;
    localparam int unsigned LONG_STALL_AFTER  = 500;
    localparam int unsigned RANDOM_SETTINGS   = 5;
    localparam int unsigned RANDOM_TICKS      = 180;
    localparam int unsigned AMBIENT_TOP       = (1 << AMBIENT_W) - 1;
    localparam int unsigned HOLD_TOP          = (1 << HOLD_W) - 1;
    localparam int unsigned STEP_TOP          = (1 << STEP_W) - 1;
    // far beyond the slowest legal run
    localparam realtime     WATCHDOG_NS       = 3_000_000.0;

    typedef struct {
        int unsigned threshold;
        int unsigned hold;
        int unsigned step;
        int unsigned ticks;
        int unsigned motion_pct;
        bit          poke_unused;
    } t_fade_setting;

    typedef enum {
        STALL_NONE,
        STALL_COIN,
        STALL_EVERY_THIRD,
        STALL_SPARSE
    } t_stall_style;

    logic                   clk   = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    mlfc_tick_if   tick_if ();
    mlfc_result_if result_if ();

    fade_scoreboard fader_sb = new();

    int unsigned burst_left      = 0;
    int unsigned ticks_sent      = 0;
    int unsigned settings_used   = 0;
    bit          long_stall_done = 1'b0;

    motion_light_fade_controller uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .s_tick      (tick_if),
        .m_result    (result_if)
    );

    always begin
        #CLK_HALF_NS clk = 1'b1;
        #CLK_HALF_NS clk = 1'b0;
    end

    // hard stop in case the block locks up
    initial begin
        #(WATCHDOG_NS);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // handshake monitor: sampled at the edge, before any driver update lands
    always @(posedge clk) begin
        if (tick_if.valid && tick_if.ready)
            fader_sb.tick_taken(tick_if.motion, tick_if.ambient_level);
        if (result_if.valid && result_if.ready)
            fader_sb.result_seen(result_if.brightness, result_if.light_mode, $realtime);
    end

    // result side back-pressure: stretches of different stall patterns, plus
    // one long hold-off so the two internal registers fill and tick ready drops
    initial begin
        t_stall_style style;
        int unsigned  stretch;
        result_if.ready <= 1'b0;
        while (!rst_n) @(posedge clk);
        forever begin
            if (!long_stall_done && fader_sb.checked >= LONG_STALL_AFTER) begin
                repeat (LONG_STALL_CYCLES) begin
                    @(posedge clk);
                    result_if.ready <= 1'b0;
                end
                long_stall_done = 1'b1;
            end
            style   = t_stall_style'($urandom_range(0, 3));
            stretch = $urandom_range(16, 120);
            for (int unsigned c = 0; c < stretch; c++) begin
                @(posedge clk);
                case (style)
                    STALL_NONE:        result_if.ready <= 1'b1;
                    STALL_COIN:        result_if.ready <= 1'($urandom_range(0, 1));
                    STALL_EVERY_THIRD: result_if.ready <= (c % 3) != 0;
                    default:           result_if.ready <= $urandom_range(0, 7) != 0;
                endcase
            end
        end
    end

    // one tick request; the sender runs in bursts with random gaps between
    // them, valid stays high from one request to the next inside a burst
    task automatic send_tick(input logic motion, input logic [AMBIENT_W-1:0] ambient);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                tick_if.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 48);
        end
        burst_left--;
        tick_if.valid         <= 1'b1;
        tick_if.motion        <= motion;
        tick_if.ambient_level <= ambient;
        @(posedge clk);
        while (!tick_if.ready) @(posedge clk);
        ticks_sent++;
    endtask

    // stop offering and wait until every result has come back
    task automatic rest_drained();
        tick_if.valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (fader_sb.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // write enable stays high across back-to-back writes, the caller lowers it
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0]  data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        fader_sb.write_reg(idx, data);
    endtask

    task automatic apply_setting(input t_fade_setting s);
        rest_drained();
        if (s.poke_unused)
            write_reg(CFG_UNUSED, CFG_DATA_W'($urandom_range(0, HOLD_TOP)));
        write_reg(CFG_DARK_THRESHOLD, CFG_DATA_W'(s.threshold));
        write_reg(CFG_HOLD_TICKS, CFG_DATA_W'(s.hold));
        write_reg(CFG_FADE_STEP_TICKS, CFG_DATA_W'(s.step));
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    // light samples lean towards the dark side and the threshold boundary
    function automatic logic [AMBIENT_W-1:0] pick_ambient(input int unsigned threshold);
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return AMBIENT_W'((threshold == 0) ? 0 : threshold - 1);
            3:       return AMBIENT_W'(threshold);
            4, 5:    return AMBIENT_W'($urandom_range(0, AMBIENT_TOP));
            default: return AMBIENT_W'((threshold == 0) ? $urandom_range(0, AMBIENT_TOP)
                                                         : $urandom_range(0, threshold - 1));
        endcase
    endfunction

    task automatic run_setting(input t_fade_setting s);
        apply_setting(s);
        repeat (s.ticks)
            send_tick($urandom_range(0, 99) < s.motion_pct, pick_ambient(s.threshold));
    endtask

    initial begin
        t_fade_setting         plan[$];
        logic [AMBIENT_W:0]    directed[$];

        tick_if.valid         <= 1'b0;
        tick_if.motion        <= 1'b0;
        tick_if.ambient_level <= '0;
        cfg_we                <= 1'b0;
        cfg_index             <= '0;
        cfg_data              <= '0;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed, on the reset register values (threshold 500, step 10):
        // quiet idle, bright light, motion right at the threshold, start from
        // dark, then a full step interval with alternating bit patterns
        directed = '{
            {1'b0, 10'd0},   {1'b1, 10'd1023}, {1'b1, 10'd500},  {1'b0, 10'd499},
            {1'b1, 10'd499}, {1'b0, 10'd1023}, {1'b1, 10'd0},    {1'b0, 10'd682},
            {1'b1, 10'd341}, {1'b0, 10'd0},    {1'b1, 10'd1023}, {1'b0, 10'd5},
            {1'b1, 10'd1018}, {1'b0, 10'd0},   {1'b0, 10'd1023}, {1'b1, 10'd512},
            {1'b0, 10'd511}
        };
        foreach (directed[i])
            send_tick(directed[i][AMBIENT_W], directed[i][AMBIENT_W-1:0]);

        // dark for all but the brightest sample, no hold time, zero step interval behaving as one
        plan.push_back('{threshold: AMBIENT_TOP, hold: 0, step: 0, ticks: 250,
                         motion_pct: 25, poke_unused: 1'b0});
        // no motion at all: whatever was going on runs out through hold and
        // the fade down to a dark idle
        plan.push_back('{threshold: AMBIENT_TOP, hold: 2, step: 1, ticks: 520,
                         motion_pct: 0, poke_unused: 1'b0});
        // never dark enough, plus a write to the unused index
        plan.push_back('{threshold: 0, hold: 5, step: 1, ticks: 60,
                         motion_pct: 50, poke_unused: 1'b1});
        // longest hold and slowest fade
        plan.push_back('{threshold: 512, hold: HOLD_TOP, step: STEP_TOP, ticks: 100,
                         motion_pct: 50, poke_unused: 1'b0});
        // mixed settings with short hold and fast fades so full cycles occur
        repeat (RANDOM_SETTINGS)
            plan.push_back('{threshold: $urandom_range(1, AMBIENT_TOP),
                             hold: $urandom_range(0, 30), step: $urandom_range(1, 3),
                             ticks: RANDOM_TICKS, motion_pct: $urandom_range(0, 30),
                             poke_unused: 1'b0});

        foreach (plan[p]) run_setting(plan[p]);
        rest_drained();

        $display("covered %0d tick requests across %0d register settings, %0d results compared",
                 ticks_sent, settings_used + 1, fader_sb.checked);
        $display("fader saw %0d starts, %0d hold expiries, %0d aborted fades, %0d fades to dark",
                 fader_sb.starts, fader_sb.expiries, fader_sb.aborts, fader_sb.fade_outs);

        if (fader_sb.errors == 0 && fader_sb.pending() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
